@@ rtl/core/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the pressure compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DivBits = 32;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } t_reg_idx;

    // one bit-step of a restoring divider on magnitudes
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] num;
        logic [31:0] den;
    } t_div;

endpackage

@@ rtl/core/bpc_div_cell.sv @@
// ----------------------------------------------------------------------------
// bpc_div_cell
// One restoring-division step: shifts in one numerator bit, subtracts.
// ----------------------------------------------------------------------------
module bpc_div_cell (
    input  bpc_pkg::t_div i_d,
    output bpc_pkg::t_div o_d
);
    logic [32:0] w_rem;
    logic [32:0] w_dif;

    always_comb begin
        w_rem = {i_d.rem, i_d.num[31]};
        w_dif = w_rem - {1'b0, i_d.den};
        o_d.den = i_d.den;
        o_d.num = {i_d.num[30:0], 1'b0};
        if (!w_dif[32]) begin
            o_d.rem = w_dif[31:0];
            o_d.quo = {i_d.quo[30:0], 1'b1};
        end else begin
            o_d.rem = w_rem[31:0];
            o_d.quo = {i_d.quo[30:0], 1'b0};
        end
    end
endmodule

@@ rtl/core/bpc_div_chain.sv @@
// ----------------------------------------------------------------------------
// bpc_div_chain
// Pipelined unsigned divider: a row of division cells, a register after
// every second cell, with side data carried alongside.
// ----------------------------------------------------------------------------
module bpc_div_chain (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_num,
    input  logic [31:0]            i_den,
    input  logic [255:0]           i_side,
    output logic [31:0]            o_quo,
    output logic [255:0]           o_side
);
    localparam int Stages = bpc_pkg::DivBits / 2;

    bpc_pkg::t_div w_in;
    bpc_pkg::t_div r_d [Stages];
    bpc_pkg::t_div w_m [Stages];
    bpc_pkg::t_div w_o [Stages];
    logic [255:0]  r_s [Stages];

    assign w_in = '{rem: 32'd0, quo: 32'd0, num: i_num, den: i_den};

    for (genvar g = 0; g < Stages; g++) begin : g_st
        if (g == 0) begin : g_head
            bpc_div_cell u_a (.i_d(w_in), .o_d(w_m[g]));
        end else begin : g_body
            bpc_div_cell u_a (.i_d(r_d[g-1]), .o_d(w_m[g]));
        end
        bpc_div_cell u_b (.i_d(w_m[g]), .o_d(w_o[g]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Stages; k++) r_d[k] <= w_o[k];
            r_s[0] <= i_side;
            for (int k = 1; k < Stages; k++) r_s[k] <= r_s[k-1];
        end
    end

    assign o_quo  = r_d[Stages-1].quo;
    assign o_side = r_s[Stages-1];
endmodule

@@ rtl/core/barometric_pressure_compensation_core.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Fixed-point temperature and pressure compensation of a barometer.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one item per cycle sustained while
// the output is not held. The pipe is two 16-stage divider chains (two division
// cells per register) and twelve arithmetic stages; the whole pipe stalls when
// the output is held. Calibration words must be written while idle.
module barometric_pressure_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_temperature[15:0], pressure_msb[23:16], pressure_lsb[31:24],
    // pressure_xlsb[39:32]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pressure_pa[31:0], temperature_tenths[47:32]
    output logic [47:0] m_axis_tdata,
    // div_error
    output logic        m_axis_tuser
);
    localparam int Lat = 44;

    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;
    logic        w_en;
    logic [Lat-1:0] r_v;

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_v[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
            r_oss <= 2'd3;
            r_v <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bpc_pkg::REG_AC1_AC2: r_c0 <= i_cfg_data;
                    bpc_pkg::REG_AC3_AC4: r_c1 <= i_cfg_data;
                    bpc_pkg::REG_AC5_AC6: r_c2 <= i_cfg_data;
                    bpc_pkg::REG_B1_B2:   r_c3 <= i_cfg_data;
                    bpc_pkg::REG_MC_MD:   r_c4 <= i_cfg_data;
                    bpc_pkg::REG_OSS:     r_oss <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (w_en) r_v <= {r_v[Lat-2:0], s_axis_tvalid};
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] ac4, ac5, ac6;
    always_comb begin
        ac1 = 32'(signed'(r_c0[31:16])); ac2 = 32'(signed'(r_c0[15:0]));
        ac3 = 32'(signed'(r_c1[31:16])); ac4 = {16'd0, r_c1[15:0]};
        ac5 = {16'd0, r_c2[31:16]};      ac6 = {16'd0, r_c2[15:0]};
        b1  = 32'(signed'(r_c3[31:16])); b2  = 32'(signed'(r_c3[15:0]));
        mc  = 32'(signed'(r_c4[31:16])); md  = 32'(signed'(r_c4[15:0]));
    end

    // stage A: X1 product
    logic [31:0] r_a_up, r_a_prod;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_prod <= 32'(({16'd0, s_axis_tdata[15:0]} - ac6) * ac5);
            r_a_up <= 32'({8'd0, s_axis_tdata[23:16], s_axis_tdata[31:24],
                           s_axis_tdata[39:32]} >> (4'd8 - {2'd0, r_oss}));
        end
    end

    // stage B: x1, den, signed-division magnitudes
    logic signed [31:0] r_b_x1;
    logic [31:0] r_b_up, r_b_num, r_b_den;
    logic r_b_neg, r_b_z;
    logic signed [31:0] w_x1, w_den, w_mc;
    always_comb begin
        w_x1 = signed'(r_a_prod) >>> 15;
        w_den = w_x1 + md;
        w_mc = mc <<< 11;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_x1 <= w_x1; r_b_up <= r_a_up;
            r_b_z <= (w_den == 0);
            r_b_neg <= w_mc[31] ^ w_den[31];
            r_b_num <= w_mc[31] ? 32'(-w_mc) : w_mc;
            r_b_den <= w_den[31] ? 32'(-w_den) : w_den;
        end
    end

    logic [31:0] w_q1;
    logic [255:0] w_s1;
    bpc_div_chain u_div_t (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_b_num), .i_den(r_b_den),
        .i_side({190'd0, r_b_neg, r_b_z, r_b_up, r_b_x1}),
        .o_quo(w_q1), .o_side(w_s1)
    );

    // stage C: B5, B6
    logic signed [31:0] r_c_b5, r_c_b6;
    logic [31:0] r_c_up;
    logic r_c_z;
    logic signed [31:0] w_x2, w_b5;
    always_comb begin
        w_x2 = w_s1[65] ? 32'(-w_q1) : w_q1;
        w_b5 = signed'(w_s1[31:0]) + w_x2;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_b5 <= w_b5; r_c_b6 <= w_b5 - 32'sd4000;
            r_c_up <= w_s1[63:32]; r_c_z <= w_s1[64];
        end
    end

    // stage D: products on B6
    logic signed [31:0] r_d_sq, r_d_p2, r_d_p3, r_d_b5;
    logic [31:0] r_d_up;
    logic r_d_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_sq <= (r_c_b6 * r_c_b6) >>> 12;
            r_d_p2 <= ac2 * r_c_b6;
            r_d_p3 <= ac3 * r_c_b6;
            r_d_b5 <= r_c_b5;
            r_d_up <= r_c_up; r_d_z <= r_c_z;
        end
    end

    // stage E: products on sq
    logic signed [31:0] r_e_pb2, r_e_pb1, r_e_p2, r_e_p3, r_e_b5;
    logic [31:0] r_e_up;
    logic r_e_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_pb2 <= b2 * r_d_sq; r_e_pb1 <= b1 * r_d_sq;
            r_e_p2 <= r_d_p2; r_e_p3 <= r_d_p3; r_e_b5 <= r_d_b5;
            r_e_up <= r_d_up; r_e_z <= r_d_z;
        end
    end

    // stage F: B3, X3 for B4
    logic signed [31:0] r_f_b3, r_f_x3, r_f_b5;
    logic [31:0] r_f_up;
    logic r_f_z;
    logic signed [31:0] w_x3a, w_x3b;
    always_comb begin
        w_x3a = (r_e_pb2 >>> 11) + (r_e_p2 >>> 11);
        w_x3b = (r_e_p3 >>> 13) + (r_e_pb1 >>> 16) + 32'sd2;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_b3 <= ((((ac1 <<< 2) + w_x3a) <<< r_oss) + 32'sd2) >>> 2;
            r_f_x3 <= (w_x3b >>> 2) + 32'sd32768;
            r_f_b5 <= r_e_b5; r_f_up <= r_e_up; r_f_z <= r_e_z;
        end
    end

    // stage G: B4, B7
    logic [31:0] r_g_b4, r_g_b7;
    logic signed [31:0] r_g_b5;
    logic r_g_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_b4 <= (ac4 * r_f_x3) >> 15;
            r_g_b7 <= (r_f_up - r_f_b3) * (32'd50000 >> r_oss);
            r_g_b5 <= r_f_b5; r_g_z <= r_f_z;
        end
    end

    // stage H: dividend select
    logic [31:0] r_h_num, r_h_den;
    logic signed [31:0] r_h_b5;
    logic r_h_hi, r_h_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_hi <= r_g_b7[31];
            r_h_num <= r_g_b7[31] ? r_g_b7 : {r_g_b7[30:0], 1'b0};
            r_h_den <= r_g_b4;
            r_h_b5 <= r_g_b5;
            r_h_z <= r_g_z || (r_g_b4 == 32'd0);
        end
    end

    logic [31:0] w_q2;
    logic [255:0] w_s2;
    bpc_div_chain u_div_p (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_h_num), .i_den(r_h_den),
        .i_side({222'd0, r_h_hi, r_h_z, r_h_b5}),
        .o_quo(w_q2), .o_side(w_s2)
    );

    // stage I: p, x1 base
    logic signed [31:0] r_i_p, r_i_x8, r_i_b5;
    logic r_i_z;
    logic signed [31:0] w_p;
    assign w_p = w_s2[33] ? {w_q2[30:0], 1'b0} : w_q2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_p <= w_p; r_i_x8 <= w_p >>> 8;
            r_i_b5 <= w_s2[31:0]; r_i_z <= w_s2[32];
        end
    end

    // stage J: square, -7357 product
    logic signed [31:0] r_j_sq, r_j_m2, r_j_p, r_j_b5;
    logic r_j_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_sq <= r_i_x8 * r_i_x8;
            r_j_m2 <= -32'sd7357 * r_i_p;
            r_j_p <= r_i_p; r_j_b5 <= r_i_b5; r_j_z <= r_i_z;
        end
    end

    // stage K: 3038 product
    logic signed [31:0] r_k_m1, r_k_m2, r_k_p, r_k_b5;
    logic r_k_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_m1 <= r_j_sq * 32'sd3038;
            r_k_m2 <= r_j_m2; r_k_p <= r_j_p; r_k_b5 <= r_j_b5; r_k_z <= r_j_z;
        end
    end

    // stage L: output
    logic signed [31:0] w_pf, w_t;
    logic signed [15:0] w_ts;
    always_comb begin
        w_pf = r_k_p + ((((r_k_m1 >>> 16) + (r_k_m2 >>> 16)) + 32'sd3791) >>> 4);
        w_t = (r_k_b5 + 32'sd8) >>> 4;
        if (w_t > 32'sd32767) w_ts = 16'sh7fff;
        else if (w_t < -32'sd32768) w_ts = 16'sh8000;
        else w_ts = w_t[15:0];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= r_k_z ? 48'd0 : {w_ts, w_pf};
            m_axis_tuser <= r_k_z;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
        else $error("error result not zero");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("accept while output stalled");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |=> r_v[0] == $past(s_axis_tvalid))
        else $error("valid pipe lost item");
`endif
endmodule
